// ===== hdl/tfp_pkg.sv =====
// Shared types, constants and the built-in name hash table of the frame parser.
package tfp_pkg;

	// Sizes and widths
	localparam int unsigned MAX_PAYLOAD   = 32;
	localparam int unsigned TABLE_ENTRIES = 16;
	localparam int unsigned ID_BYTES      = 16;
	localparam int unsigned NAME_COUNT    = 16;
	localparam int unsigned NAME_LEN      = 16;
	localparam int unsigned CNT_W         = 6;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned HASH_W        = 32;

	// Frame layout
	localparam logic [CNT_W-1:0] STATUS_LEN   = CNT_W'(10);
	localparam logic [CNT_W-1:0] IDENT_LEN    = CNT_W'(26);
	localparam logic [CNT_W-1:0] IDENT_OFFSET = CNT_W'(9);
	localparam logic [CNT_W-1:0] IDENT_END    = CNT_W'(9 + ID_BYTES);
	localparam logic [CNT_W-1:0] PAYLOAD_CAP  = CNT_W'(MAX_PAYLOAD);
	localparam logic [HASH_W-1:0] HASH_SEED   = 32'd5381;

	// Register reset values
	localparam logic [7:0]       HEADER_RESET = 8'h7f;
	localparam logic [CNT_W-1:0] MAXLEN_RESET = CNT_W'(32);

	// Input command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_IDLE = 1'b1;

	// Configuration register indexes
	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_MAXLEN = 1'b1;

	// Frame kind codes
	localparam logic [1:0] KIND_OTHER  = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_IDENT  = 2'd2;

	typedef logic [TABLE_ENTRIES-1:0][HASH_W-1:0] hash_tbl_t;

	// One result item
	typedef struct packed {
		logic [1:0]        frame_kind;
		logic [CNT_W-1:0]  payload_length;
		logic              match_found;
		logic [IDX_W-1:0]  match_index;
		logic [HASH_W-1:0] id_hash;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic start_frame;
		logic data_step;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hdr_match;
		logic len_ok;
		logic frame_done;
	} dp_status_t;

	// Built-in names, first byte in the top bits, zero padded
	function automatic logic [NAME_LEN*8-1:0] name_line(input int unsigned i);
		logic [NAME_LEN*8-1:0] l;
		unique case (i)
			0:  l = 128'hc8f0bdf0_00000000_00000000_00000000;
			1:  l = 128'hcdbbc6c6_b5dac8fd_b5c0b7e2_cbf8cfdf;
			2:  l = 128'hd1aad5bd_cfe6bdad_00000000_00000000;
			3:  l = 128'hc7bfb6c9_cedabdad_00000000_00000000;
			4:  l = 128'hd5bcc1ec_d7f1d2e5_00000000_00000000;
			5:  l = 128'hcbc4b6c9_b3e0cbae_00000000_00000000;
			6:  l = 128'hc7c9b6c9_bdf0c9b3_bdad0000_00000000;
			7:  l = 128'hc7bfb6c9_b4f3b6c9_bad30000_00000000;
			8:  l = 128'hb7c9b6e1_e3f2b6a8_c7c50000_00000000;
			9:  l = 128'hc5c0d1a9_c9bd0000_00000000_00000000;
			10: l = 128'hedaeb9a6_bbe1caa6_00000000_00000000;
			11: l = 128'hb9fdb2dd_b5d80000_00000000_00000000;
			12: l = 128'hbca4d5bd_c0b0d7d3_bfda0000_00000000;
			13: l = 128'hbbe1c4fe_b4f3bbe1_caa60000_00000000;
			14: l = 128'hcee2c6f0_d5f2bbe1_d2e90000_00000000;
			15: l = 128'hd1d3b0b2_00000000_00000000_00000000;
			default: l = '0;
		endcase
		return l;
	endfunction

	// DJB2 over each name, worked out at elaboration
	function automatic hash_tbl_t build_table();
		hash_tbl_t t;
		logic [HASH_W-1:0] h;
		logic [NAME_LEN*8-1:0] l;
		logic [7:0] b;
		for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
			h = HASH_SEED;
			l = name_line(i % NAME_COUNT);
			for (int unsigned k = 0; k < ID_BYTES; k++) begin
				b = (k < NAME_LEN) ? l[NAME_LEN*8-1-8*k -: 8] : 8'd0;
				h = HASH_W'(h * 33) + {24'd0, b};
			end
			t[i] = h;
		end
		return t;
	endfunction

	localparam hash_tbl_t NAME_HASH = build_table();

endpackage

// ===== hdl/tfp_if.sv =====
// Stream interfaces for the received bytes and the frame results.
interface tfp_rx_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface tfp_res_if
	import tfp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [1:0]        frame_kind;
	logic [CNT_W-1:0]  payload_length;
	logic              match_found;
	logic [IDX_W-1:0]  match_index;
	logic [HASH_W-1:0] id_hash;

	modport source (output valid, output frame_kind, output payload_length,
		output match_found, output match_index, output id_hash, input ready);
	modport sink   (input valid, input frame_kind, input payload_length,
		input match_found, input match_index, input id_hash, output ready);
endinterface

// ===== hdl/tfp_ctrl.sv =====
// Parse state machine: hunt for header, take length, collect payload.
module tfp_ctrl
	import tfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       command,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_HUNT = 3'b001,
		ST_LEN  = 3'b010,
		ST_DATA = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (fire) begin
			if (command == CMD_IDLE) begin
				state_d = ST_HUNT;
			end else begin
				unique case (state_q)
					ST_HUNT: begin
						state_d = status.hdr_match ? ST_LEN : ST_HUNT;
					end
					ST_LEN: begin
						if (status.len_ok) begin
							cmd.start_frame = 1'b1;
							state_d         = ST_DATA;
						end else begin
							state_d = ST_HUNT;
						end
					end
					ST_DATA: begin
						cmd.data_step = 1'b1;
						if (status.frame_done) begin
							cmd.emit = 1'b1;
							state_d  = ST_HUNT;
						end
					end
					default: state_d = ST_HUNT;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/tfp_dp.sv =====
// Datapath: config registers, byte counter, running hash, table match, result register.
module tfp_dp
	import tfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_wdata,
	input  logic [7:0]       data_byte,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  logic             res_ready,
	output logic             res_valid,
	output result_t          res
);

	logic [7:0]        header_q;
	logic [CNT_W-1:0]  max_len_q;
	logic [CNT_W-1:0]  exp_len_q;
	logic [CNT_W-1:0]  count_q;
	logic [HASH_W-1:0] hash_q;
	logic              res_valid_q;
	result_t           res_q;

	logic [CNT_W-1:0]  limit;
	logic [CNT_W-1:0]  count_next;
	logic [CNT_W-1:0]  need;
	logic              in_ident;
	logic [HASH_W-1:0] hash_next;
	logic              found;
	logic [IDX_W-1:0]  found_idx;
	result_t           res_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RESET;
			max_len_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER: header_q  <= cfg_wdata;
				CFG_MAXLEN: max_len_q <= cfg_wdata[CNT_W-1:0];
				default:    header_q  <= header_q;
			endcase
		end
	end

	// Length limit and frame progress
	assign limit      = (max_len_q > PAYLOAD_CAP) ? PAYLOAD_CAP : max_len_q;
	assign count_next = count_q + CNT_W'(1);
	assign need       = (exp_len_q != '0) ? exp_len_q : CNT_W'(1);
	assign in_ident   = (count_q >= IDENT_OFFSET) && (count_q < IDENT_END);
	assign hash_next  = {hash_q[HASH_W-6:0], 5'd0} + hash_q + {24'd0, data_byte};

	assign status.hdr_match  = (data_byte == header_q);
	assign status.len_ok     = ({2'd0, limit} >= data_byte);
	assign status.frame_done = (count_next >= need);

	// Frame counters and running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
			count_q   <= '0;
			hash_q    <= HASH_SEED;
		end else if (cmd.start_frame) begin
			exp_len_q <= data_byte[CNT_W-1:0];
			count_q   <= '0;
			hash_q    <= HASH_SEED;
		end else if (cmd.data_step) begin
			count_q <= count_next;
			if (in_ident) begin
				hash_q <= hash_next;
			end
		end
	end

	// Table compare, lowest matching entry wins; the last byte lies past the hashed span
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (NAME_HASH[i] == hash_q) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
		end
	end

	// Result assembly
	always_comb begin
		res_d                = '0;
		res_d.payload_length = count_next;
		if (count_next == STATUS_LEN) begin
			res_d.frame_kind = KIND_STATUS;
		end else if (count_next == IDENT_LEN) begin
			res_d.frame_kind  = KIND_IDENT;
			res_d.id_hash     = hash_q;
			res_d.match_found = found;
			res_d.match_index = found_idx;
		end else begin
			res_d.frame_kind = KIND_OTHER;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/tag_frame_parse_and_id_match.sv =====
// Top level: frame parser with identity hash match.
// Throughput: one byte or idle event per cycle while the result register is free or draining.
// Latency: a frame's result is valid in the cycle after its last payload byte transfer.
// The result register holds one finished frame; input stalls only while it waits unread.
// Reset (arst_n low, asynchronous): parser hunts for header, registers return to 0x7f and 32.
module tag_frame_parse_and_id_match
	import tfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	tfp_rx_if.sink     rx,
	tfp_res_if.source  result
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       res_valid;
	result_t    res;
	logic       fire;

	// Input is taken when the result slot is empty or being emptied
	assign rx.ready = !res_valid || result.ready;
	assign fire     = rx.valid && rx.ready;

	tfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.command (rx.command),
		.status  (status),
		.cmd     (cmd)
	);

	tfp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.data_byte (rx.data_byte),
		.cmd       (cmd),
		.status    (status),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res       (res)
	);

	assign result.valid          = res_valid;
	assign result.frame_kind     = res.frame_kind;
	assign result.payload_length = res.payload_length;
	assign result.match_found    = res.match_found;
	assign result.match_index    = res.match_index;
	assign result.id_hash        = res.id_hash;

endmodule
